// ===== sv/u2u8_pkg.sv =====
`default_nettype none

package u2u8_pkg;

    // Source format codes held in the configuration register.
    typedef logic [1:0] fmt_t;

    localparam fmt_t FMT_U16LE = 2'd0;
    localparam fmt_t FMT_U16BE = 2'd1;
    localparam fmt_t FMT_U32LE = 2'd2;
    localparam fmt_t FMT_U32BE = 2'd3;

    // Surrogate tags in the top six bits of a UTF-16 unit.
    localparam logic [5:0] SUR_HI_TAG = 6'b110110;
    localparam logic [5:0] SUR_LO_TAG = 6'b110111;

    localparam logic [15:0] SUR_HI_BASE    = 16'hD800;
    localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;
    localparam logic [31:0] CP_MAX         = 32'h0010FFFF;
    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;

    // Largest run of bytes one word can cause, and the length of a lone surrogate.
    localparam int unsigned MAX_RUN = 6;
    localparam logic [2:0] FLUSH_LEN = 3'd3;

    // Encoding of one code point: up to four bytes, first byte in slot 0.
    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      count;
    } utf8_enc_t;

    // Run of bytes handed to the serialiser, first byte in slot 0.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] data;
        logic [2:0]              count;
    } u2u8_burst_t;

    // UTF-8 encoder; values beyond the Unicode range become U+FFFD.
    function automatic utf8_enc_t utf8_encode(input logic [31:0] cp);
        logic [20:0] c;
        utf8_enc_t   r;
        c = (cp > CP_MAX) ? CP_REPLACEMENT : cp[20:0];
        r.data = '0;
        priority if (c <= 21'h00007F)
        begin
            r.data[0] = {1'b0, c[6:0]};
            r.count   = 3'd1;
        end
        else if (c <= 21'h0007FF)
        begin
            r.data[0] = {3'b110, c[10:6]};
            r.data[1] = {2'b10, c[5:0]};
            r.count   = 3'd2;
        end
        else if (c <= 21'h00FFFF)
        begin
            r.data[0] = {4'b1110, c[15:12]};
            r.data[1] = {2'b10, c[11:6]};
            r.data[2] = {2'b10, c[5:0]};
            r.count   = 3'd3;
        end
        else
        begin
            r.data[0] = {5'b11110, c[20:18]};
            r.data[1] = {2'b10, c[17:12]};
            r.data[2] = {2'b10, c[11:6]};
            r.data[3] = {2'b10, c[5:0]};
            r.count   = 3'd4;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/u2u8_if.sv =====
`default_nettype none

// Input channel: one code unit per word.
interface u2u8_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_unit;
    logic        end_of_stream;

    modport source (output valid, output code_unit, output end_of_stream, input ready);
    modport sink   (input valid, input code_unit, input end_of_stream, output ready);
endinterface

// Output channel: one UTF-8 byte per word.
interface u2u8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// Configuration write channel for the source format register.
interface u2u8_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/utf16_utf32_to_utf8_transcoder.sv =====
// UTF-16 / UTF-32 to UTF-8 transcoder.
//
// src takes one code unit per word, first arriving byte in bits 7:0, with
// end_of_stream on the final unit. cfg writes the two-bit source format
// (UTF-16 LE, UTF-16 BE, UTF-32 LE, UTF-32 BE); it is always ready, and a
// write also drops any high surrogate that is waiting for its partner.
// dst gives the UTF-8 bytes one per word; last_of_run marks the final byte
// caused by one input word.
//
// Each word passes through the input register and then the serialiser before
// its first byte is offered on dst, and waits there while the serialiser is
// busy. dst moves one byte per cycle while dst is ready; a held high surrogate
// gives no byte. The single output serialiser sets this rate.
//
// When dst stalls, the current run waits in the serialiser and src still
// takes one more word into the input register, if it is empty, before ready falls.
// Reset empties both stages, clears the held surrogate and selects UTF-16 LE.
`default_nettype none

module utf16_utf32_to_utf8_transcoder (
    input  logic      clk,
    input  logic      rst_n,
    u2u8_cfg_if.sink  cfg,
    u2u8_in_if.sink   src,
    u2u8_out_if.source dst
);

    import u2u8_pkg::*;

    fmt_t        fmt_reg;
    fmt_t        fmt_next;
    logic        held_valid_reg;
    logic        held_valid_next;
    logic [9:0]  held_payload_reg;
    logic [9:0]  held_payload_next;
    logic        a_valid_reg;
    logic        a_valid_next;
    logic [31:0] a_unit_reg;
    logic        a_eos_reg;

    logic        ser_free;
    logic        a_move;
    logic        is16;
    logic        swap;
    logic [15:0] u16;
    logic [31:0] u32;
    logic        is_hi;
    logic        is_lo;
    logic        pair;
    logic        hold;
    logic        flush;
    logic        main_en;
    logic [31:0] main_cp;
    logic [20:0] pair_cp;
    logic [2:0]  main_n;
    utf8_enc_t   main_enc;
    utf8_enc_t   flush_enc;
    u2u8_burst_t burst;
    logic        load;

    assign cfg.ready = 1'b1;

    // The input register moves on whenever the serialiser can take its run.
    assign a_move    = a_valid_reg && ser_free;
    assign src.ready = !a_valid_reg || ser_free;

    // Byte order and surrogate classification of the registered unit.
    always_comb
    begin
        is16  = (fmt_reg == FMT_U16LE) || (fmt_reg == FMT_U16BE);
        swap  = (fmt_reg == FMT_U16BE) || (fmt_reg == FMT_U32BE);
        u16   = swap ? {a_unit_reg[7:0], a_unit_reg[15:8]} : a_unit_reg[15:0];
        u32   = swap ? {a_unit_reg[7:0], a_unit_reg[15:8], a_unit_reg[23:16],
                        a_unit_reg[31:24]} : a_unit_reg;
        is_hi = (u16[15:10] == SUR_HI_TAG);
        is_lo = (u16[15:10] == SUR_LO_TAG);
        pair  = is16 && held_valid_reg && is_lo;
        hold  = is16 && !pair && is_hi && !a_eos_reg;
        flush = is16 && held_valid_reg && !pair;
        pair_cp = {1'b0, held_payload_reg, u16[9:0]} + CP_SUPP_BASE;
    end

    // Code point to encode for this word.
    always_comb
    begin
        main_en = !hold;
        if (!is16)
        begin
            main_cp = u32;
        end
        else if (pair)
        begin
            main_cp = {11'h000, pair_cp};
        end
        else
        begin
            main_cp = {16'h0000, u16};
        end
    end

    // Encode, with the lone held surrogate ahead of the unit when flushed.
    always_comb
    begin
        main_enc  = utf8_encode(main_cp);
        flush_enc = utf8_encode({16'h0000, SUR_HI_BASE | {6'h00, held_payload_reg}});
        main_n    = main_en ? main_enc.count : 3'd0;
        burst.data = '0;
        if (flush)
        begin
            burst.data[2:0] = flush_enc.data[2:0];
            burst.data[5:3] = main_enc.data[2:0];
            burst.count     = FLUSH_LEN + main_n;
        end
        else
        begin
            burst.data[3:0] = main_enc.data;
            burst.count     = main_n;
        end
    end

    assign load = a_move && (burst.count != 3'd0);

    // Format register, surrogate holding state and input register control.
    always_comb
    begin
        fmt_next          = fmt_reg;
        held_valid_next   = held_valid_reg;
        held_payload_next = held_payload_reg;
        a_valid_next      = a_valid_reg;
        if (cfg.valid)
        begin
            fmt_next          = cfg.data;
            held_valid_next   = 1'b0;
            held_payload_next = 10'h000;
        end
        else if (a_move)
        begin
            held_valid_next   = hold;
            held_payload_next = hold ? u16[9:0] : 10'h000;
        end
        if (src.valid && src.ready)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_move)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg          <= FMT_U16LE;
            held_valid_reg   <= 1'b0;
            held_payload_reg <= 10'h000;
            a_valid_reg      <= 1'b0;
        end
        else
        begin
            fmt_reg          <= fmt_next;
            held_valid_reg   <= held_valid_next;
            held_payload_reg <= held_payload_next;
            a_valid_reg      <= a_valid_next;
        end
    end

    // Input payload is captured on every accepted word.
    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            a_unit_reg <= src.code_unit;
            a_eos_reg  <= src.end_of_stream;
        end
    end

    u2u8_serializer u_ser (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .burst (burst),
        .free  (ser_free),
        .dst   (dst)
    );

endmodule

`default_nettype wire

// ===== sv/u2u8_serializer.sv =====
`default_nettype none

module u2u8_serializer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  u2u8_pkg::u2u8_burst_t burst,
    output logic                  free,
    u2u8_out_if.source            dst
);

    import u2u8_pkg::*;

    logic [2:0]              cnt_reg;
    logic [2:0]              cnt_next;
    logic [MAX_RUN-1:0][7:0] data_reg;
    logic [MAX_RUN-1:0][7:0] data_next;
    logic                    take;

    // The head of the run is always in slot 0.
    assign dst.valid       = (cnt_reg != 3'd0);
    assign dst.out_byte    = data_reg[0];
    assign dst.last_of_run = (cnt_reg == 3'd1);

    assign take = dst.valid && dst.ready;

    // A new run may be loaded when empty or when the final byte leaves now.
    assign free = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && dst.ready);

    // Load a fresh run, otherwise shift one byte out per taken word.
    always_comb
    begin
        cnt_next  = cnt_reg;
        data_next = data_reg;
        if (load)
        begin
            cnt_next  = burst.count;
            data_next = burst.data;
        end
        else if (take)
        begin
            cnt_next  = cnt_reg - 3'd1;
            data_next = {8'h00, data_reg[MAX_RUN-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== sv/u2u8_checker.sv =====
`default_nettype none

module u2u8_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       dst_valid,
    input logic       dst_ready,
    input logic [7:0] dst_out_byte,
    input logic       dst_last_of_run
);

    // A stalled output word holds still.
    a_dst_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_ready |=> dst_valid && $stable(dst_out_byte)
            && $stable(dst_last_of_run))
        else $error("output word changed while stalled");

    // An ASCII byte is a whole code point and always closes the run.
    a_ascii_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !dst_out_byte[7] |-> dst_last_of_run)
        else $error("ASCII byte not marked as last of run");

    // A lead byte of a multi-byte sequence never closes a run.
    a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && (dst_out_byte[7:6] == 2'b11) |-> !dst_last_of_run)
        else $error("lead byte marked as last of run");

    // Bytes that never occur in well-formed UTF-8 are never produced.
    a_legal_byte: assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid |-> (dst_out_byte < 8'hF5) && (dst_out_byte != 8'hC0)
            && (dst_out_byte != 8'hC1))
        else $error("illegal UTF-8 byte on output");

endmodule

bind utf16_utf32_to_utf8_transcoder u2u8_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .dst_valid       (dst.valid),
    .dst_ready       (dst.ready),
    .dst_out_byte    (dst.out_byte),
    .dst_last_of_run (dst.last_of_run)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import u2u8_pkg::*;

    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;

    // One expected UTF-8 byte with its end-of-run flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } utf8_word_t;

    // Encoding of one code point, first byte in slot 0.
    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } utf8_seq_t;

    bit   clk;
    logic rst_n;

    u2u8_cfg_if cfg_ch ();
    u2u8_in_if  src_ch ();
    u2u8_out_if dst_ch ();

    utf16_utf32_to_utf8_transcoder DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .src   (src_ch),
        .dst   (dst_ch)
    );

    // Bytes still owed by the block, oldest first.
    utf8_word_t expected_bytes[$];
    int         mismatches;

    // Shadow of the transcoder state.
    fmt_t       model_fmt;
    logic       model_held;
    logic [9:0] model_held_bits;

    // Flow control knobs, in percent per cycle, and a long receiver hold-off.
    int send_idle_pct;
    int stall_pct;
    int stall_hold;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // UTF-8 encoding of a code point; values beyond the Unicode range become U+FFFD.
    function automatic utf8_seq_t utf8_of(input logic [31:0] cp_in);
        logic [20:0] cp;
        utf8_seq_t   s;
        cp  = (cp_in > 32'h0010FFFF) ? 21'h00FFFD : cp_in[20:0];
        s.b = '0;
        if (cp < 21'h000080)
        begin
            s.len  = 3'd1;
            s.b[0] = {1'b0, cp[6:0]};
        end
        else if (cp < 21'h000800)
        begin
            s.len  = 3'd2;
            s.b[0] = {3'b110, cp[10:6]};
            s.b[1] = {2'b10, cp[5:0]};
        end
        else if (cp < 21'h010000)
        begin
            s.len  = 3'd3;
            s.b[0] = {4'b1110, cp[15:12]};
            s.b[1] = {2'b10, cp[11:6]};
            s.b[2] = {2'b10, cp[5:0]};
        end
        else
        begin
            s.len  = 3'd4;
            s.b[0] = {5'b11110, cp[20:18]};
            s.b[1] = {2'b10, cp[17:12]};
            s.b[2] = {2'b10, cp[11:6]};
            s.b[3] = {2'b10, cp[5:0]};
        end
        return s;
    endfunction

    task automatic queue_seq(input utf8_seq_t s, input logic mark_end);
        utf8_word_t w;
        for (int i = 0; i < s.len; i++)
        begin
            w.data = s.b[i];
            w.last = mark_end && (i == s.len - 1);
            expected_bytes.push_back(w);
        end
    endtask

    // Works out the bytes that one accepted code unit causes.
    task automatic predict_unit(input logic [31:0] raw, input logic eos);
        logic [15:0] u16;
        logic [31:0] u32;
        utf8_seq_t   flushed;
        logic        have_flush;
        have_flush = 1'b0;
        flushed    = '0;
        if (model_fmt == FMT_U32LE || model_fmt == FMT_U32BE)
        begin
            u32 = (model_fmt == FMT_U32LE) ? raw
                                           : {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
            model_held      = 1'b0;
            model_held_bits = '0;
            queue_seq(utf8_of(u32), 1'b1);
        end
        else
        begin
            u16 = (model_fmt == FMT_U16LE) ? raw[15:0] : {raw[7:0], raw[15:8]};
            if (model_held && u16 >= 16'hDC00 && u16 < 16'hE000)
            begin
                // A complete pair gives one supplementary code point.
                queue_seq(utf8_of({12'b0, model_held_bits, u16[9:0]} + 32'h00010000), 1'b1);
                model_held      = 1'b0;
                model_held_bits = '0;
            end
            else
            begin
                if (model_held)
                begin
                    flushed         = utf8_of({16'b0, 6'b110110, model_held_bits});
                    have_flush      = 1'b1;
                    model_held      = 1'b0;
                    model_held_bits = '0;
                end
                if (u16 >= 16'hD800 && u16 < 16'hDC00 && !eos)
                begin
                    // The new high surrogate waits; only the flushed one is emitted.
                    if (have_flush)
                        queue_seq(flushed, 1'b1);
                    model_held      = 1'b1;
                    model_held_bits = u16[9:0];
                end
                else
                begin
                    if (have_flush)
                        queue_seq(flushed, 1'b0);
                    queue_seq(utf8_of({16'b0, u16}), 1'b1);
                end
            end
        end
    endtask

    // Offers one word on src, idling first as the current phase asks.
    task automatic send_unit(input logic [31:0] cu, input logic eos);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            src_ch.valid <= 1'b0;
            @(negedge clk);
        end
        src_ch.valid         <= 1'b1;
        src_ch.code_unit     <= cu;
        src_ch.end_of_stream <= eos;
        @(posedge clk);
        while (!src_ch.ready)
            @(posedge clk);
        predict_unit(cu, eos);
        @(negedge clk);
    endtask

    // Stops offering words and waits for every owed byte, then lets the block settle.
    task automatic wait_drained();
        src_ch.valid <= 1'b0;
        @(negedge clk);
        while (expected_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_format(input fmt_t f);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= f;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        model_fmt       = f;
        model_held      = 1'b0;
        model_held_bits = '0;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // Places a UTF-16 unit on the wire, with random bits in the unused half.
    function automatic logic [31:0] wire16(input fmt_t f, input logic [15:0] u);
        logic [15:0] pad;
        pad = 16'($urandom);
        return (f == FMT_U16BE) ? {pad, u[7:0], u[15:8]} : {pad, u};
    endfunction

    function automatic logic [31:0] wire32(input fmt_t f, input logic [31:0] v);
        return (f == FMT_U32BE) ? {v[7:0], v[15:8], v[23:16], v[31:24]} : v;
    endfunction

    // Boundaries of each UTF-8 length, surrogate pairs and the lone surrogate cases.
    task automatic test_utf16le_directed();
        send_unit(32'h1234_0000, 1'b0);
        send_unit(32'h0000_007F, 1'b0);
        send_unit(32'hFFFF_0080, 1'b0);
        send_unit(32'h0000_07FF, 1'b0);
        send_unit(32'h0000_0800, 1'b0);
        send_unit(32'h0000_FFFF, 1'b0);
        send_unit(32'h0000_D800, 1'b0);
        send_unit(32'h0000_DC00, 1'b0);
        // A low surrogate with nothing held.
        send_unit(32'h0000_DC00, 1'b0);
        // A held surrogate flushed by a new high one, which then pairs up.
        send_unit(32'h0000_D801, 1'b0);
        send_unit(32'h0000_DBFF, 1'b0);
        send_unit(32'h0000_DFFF, 1'b0);
        // A high surrogate on the final unit is emitted at once.
        send_unit(32'h0000_D83D, 1'b1);
        // A held surrogate flushed by an ordinary final unit.
        send_unit(32'h0000_D800, 1'b0);
        send_unit(32'h0000_0041, 1'b1);
    endtask

    task automatic test_utf16be_directed();
        set_format(FMT_U16BE);
        send_unit(32'h0000_3DD8, 1'b0);
        send_unit(32'h0000_00DE, 1'b0);
        send_unit(32'hABCD_4100, 1'b1);
    endtask

    // A format write drops a waiting surrogate, even when the format is unchanged.
    task automatic test_format_write_discards();
        set_format(FMT_U16LE);
        send_unit(32'h0000_D800, 1'b0);
        set_format(FMT_U16LE);
        send_unit(32'h0000_DC00, 1'b0);
    endtask

    // Range limit, replacement character and surrogate values passed through.
    task automatic test_utf32_directed();
        set_format(FMT_U32LE);
        send_unit(32'h0010_FFFF, 1'b0);
        send_unit(32'h0011_0000, 1'b0);
        send_unit(32'h0000_DFFF, 1'b1);
        set_format(FMT_U32BE);
        send_unit(32'h00F6_0100, 1'b0);
        send_unit(32'hFFFF_FFFF, 1'b1);
    endtask

    // The receiver holds off while four-byte code points keep coming, so src must stall.
    task automatic test_long_output_hold();
        set_format(FMT_U32LE);
        send_idle_pct = 0;
        stall_pct     = 0;
        @(posedge clk);
        stall_hold = LONG_HOLD;
        @(negedge clk);
        for (int i = 0; i < 12; i++)
            send_unit(32'h0001_0000 + $urandom_range(32'h000F_FFFF, 0), 1'b0);
        wait_drained();
    endtask

    // Mostly well-formed text with random content, plus noise.
    task automatic run_random_phase(input fmt_t f, input int sidle, input int rstall,
                                    input int count);
        int   sent;
        int   pick;
        logic eos;
        set_format(f);
        send_idle_pct = sidle;
        stall_pct     = rstall;
        sent          = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99, 0);
            eos  = ($urandom_range(9, 0) == 0);
            if (f == FMT_U16LE || f == FMT_U16BE)
            begin
                if (pick < 30)
                begin
                    send_unit(wire16(f, 16'hD800 | 16'($urandom_range(16'h03FF, 0))), 1'b0);
                    send_unit(wire16(f, 16'hDC00 | 16'($urandom_range(16'h03FF, 0))), eos);
                    sent += 2;
                end
                else
                begin
                    if (pick < 40)
                        send_unit(wire16(f, 16'($urandom_range(16'hDBFF, 16'hD800))), eos);
                    else if (pick < 45)
                        send_unit(wire16(f, 16'($urandom_range(16'hDFFF, 16'hDC00))), eos);
                    else if (pick < 60)
                        send_unit(wire16(f, 16'($urandom_range(16'h007F, 0))), eos);
                    else if (pick < 75)
                        send_unit(wire16(f, 16'($urandom_range(16'h07FF, 16'h0080))), eos);
                    else if (pick < 82)
                        send_unit(wire16(f, 16'($urandom_range(16'hD7FF, 16'h0800))), eos);
                    else if (pick < 90)
                        send_unit(wire16(f, 16'($urandom_range(16'hFFFF, 16'hE000))), eos);
                    else
                        send_unit($urandom, eos);
                    sent++;
                end
            end
            else
            begin
                if (pick < 20)
                    send_unit(wire32(f, $urandom_range(32'h7F, 0)), eos);
                else if (pick < 35)
                    send_unit(wire32(f, $urandom_range(32'h7FF, 32'h80)), eos);
                else if (pick < 50)
                    send_unit(wire32(f, $urandom_range(32'hFFFF, 32'h800)), eos);
                else if (pick < 70)
                    send_unit(wire32(f, $urandom_range(32'h10FFFF, 32'h10000)), eos);
                else if (pick < 78)
                    send_unit(wire32(f, $urandom_range(32'hDFFF, 32'hD800)), eos);
                else if (pick < 88)
                    send_unit(wire32(f, $urandom_range(32'hFFFF_FFFF, 32'h11_0000)), eos);
                else
                    send_unit($urandom, eos);
                sent++;
            end
        end
        wait_drained();
    endtask

    task automatic test_random_phases();
        run_random_phase(FMT_U16LE, 0, 0, 22);
        run_random_phase(FMT_U32BE, 85, 0, 22);
        run_random_phase(FMT_U16BE, 0, 85, 22);
        run_random_phase(FMT_U32LE, 15, 15, 22);
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge clk)
    begin
        if (stall_hold > 0)
        begin
            dst_ch.ready <= 1'b0;
            stall_hold--;
        end
        else
            dst_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // Each byte taken from dst is checked against the oldest owed byte.
    always @(posedge clk)
    begin : check_output
        utf8_word_t want;
        if (rst_n && dst_ch.valid && dst_ch.ready)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last %0b",
                                          dst_ch.out_byte, dst_ch.last_of_run));
            else
            begin
                want = expected_bytes.pop_front();
                if (dst_ch.out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              dst_ch.out_byte, want.data));
                if (dst_ch.last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b on byte %02h",
                                              dst_ch.last_of_run, want.last, want.data));
            end
        end
    end

    // Watchdog: ends the run once no word has moved on any channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("utf16_utf32_to_utf8_transcoder verification failed");
        $finish;
    end

    initial
    begin
        rst_n                = 1'b0;
        src_ch.valid         = 1'b0;
        src_ch.code_unit     = '0;
        src_ch.end_of_stream = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = FMT_U16LE;
        dst_ch.ready         = 1'b0;
        mismatches           = 0;
        send_idle_pct        = 0;
        stall_pct            = 0;
        stall_hold           = 0;
        model_fmt            = FMT_U16LE;
        model_held           = 1'b0;
        model_held_bits      = '0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_utf16le_directed();
        test_utf16be_directed();
        test_format_write_discards();
        test_utf32_directed();
        test_long_output_hold();
        test_random_phases();
        wait_drained();

        if (mismatches == 0)
            $display("utf16_utf32_to_utf8_transcoder verification clean");
        else
            $display("utf16_utf32_to_utf8_transcoder verification failed");
        $finish;
    end

endmodule
